@@ rtl/oasc_pkg.sv @@
// ----------------------------------------------------------------------------
// oasc_pkg
// shared types and constants of the obstacle avoidance steering controller
// ----------------------------------------------------------------------------
package oasc_pkg;

    // range limits applied to missing or far readings, and fixed side recover and critical distances
    localparam logic [5:0] SIDE_LIMIT_CM    = 6'd40;
    localparam logic [5:0] CENTER_LIMIT_CM  = 6'd50;
    localparam logic [5:0] SIDE_RECOVER_CM  = 6'd10;
    localparam logic [5:0] SIDE_CRITICAL_CM = 6'd5;

    // distance filter weights, out of 256
    localparam logic [7:0] FILT_KEEP_W = 8'd179;
    localparam logic [6:0] FILT_NEW_W  = 7'd77;

    // steering constants
    localparam logic signed [25:0] STRAIGHT_CLAMP = 26'sd102400;
    localparam logic signed [15:0] TURN_TARGET    = 16'sd10240;
    localparam logic signed [15:0] REVERSE_TARGET = 16'sd15360;
    localparam logic signed [7:0]  STEER_KEEP_W   = 8'sd51;
    localparam logic signed [8:0]  STEER_NEW_W    = 9'sd205;

    localparam logic signed [7:0] THR_TURN    = 8'sd15;
    localparam logic signed [7:0] THR_REVERSE = -8'sd30;

    // slots of the per-lane compare vector
    localparam int AB_OPEN     = 0;  // sides: open for turning
    localparam int AB_CLEAR    = 0;  // center: clear ahead
    localparam int AB_BLOCKED  = 1;
    localparam int AB_RECOVER  = 2;  // sides: above recover distance
    localparam int AB_APPROACH = 2;  // center: above approach distance
    localparam int AB_CRITICAL = 3;  // sides: above critical distance

    typedef enum logic [3:0] {
        REG_OPEN_SIDE       = 4'd0,
        REG_CENTER_CLEAR    = 4'd1,
        REG_CENTER_BLOCKED  = 4'd2,
        REG_SIDE_BLOCKED    = 4'd3,
        REG_CENTER_APPROACH = 4'd4,
        REG_KP_GAIN         = 4'd5,
        REG_KD_GAIN         = 4'd6,
        REG_CRUISE          = 4'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        DRV_STRAIGHT = 2'd0,
        DRV_LEFT     = 2'd1,
        DRV_RIGHT    = 2'd2,
        DRV_REVERSE  = 2'd3
    } drive_state_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DECIDE,
        SEQ_PD,
        SEQ_SMOOTH,
        SEQ_FINISH
    } seq_state_t;

    typedef logic [3:0][5:0] thr_vec_t;

    typedef struct packed {
        logic [13:0] filt;
        logic [3:0]  above;
    } lane_stat_t;

    typedef struct packed {
        logic decide;
        logic pd;
        logic smooth;
        logic finish;
    } ctrl_t;

    typedef struct packed {
        logic signed [7:0] throttle;
        logic signed [6:0] steering;
        drive_state_t      drive_mode;
    } result_t;

endpackage

@@ rtl/oasc_lane.sv @@
// ----------------------------------------------------------------------------
// oasc_lane
// one range channel: clip, q6.8 iir filter and threshold compares
// ----------------------------------------------------------------------------
module oasc_lane
    import oasc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [10:0] raw,
    input  logic [5:0]  limit,
    input  thr_vec_t    thr,
    output lane_stat_t  stat
);

    logic [13:0] filt_reg;
    logic [13:0] filt_next;
    logic [5:0]  clipped;
    logic [21:0] keep_prod;
    logic [11:0] new_part;
    logic [14:0] sum;

    // zero means no echo, both cases fall back to the limit
    always_comb
    begin
        if (raw == 11'd0 || raw > {5'd0, limit})
            clipped = limit;
        else
            clipped = raw[5:0];
    end

    // the new reading is a whole cm value, so its term drops out of the shift
    assign keep_prod = filt_reg * FILT_KEEP_W;
    assign new_part  = clipped * FILT_NEW_W;
    assign sum       = {1'b0, keep_prod[21:8]} + {3'd0, new_part};
    assign filt_next = sum[13:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            filt_reg <= '0;
        else if (step)
            filt_reg <= filt_next;
    end

    always_comb
    begin
        stat.filt = filt_reg;
        for (int i = 0; i < 4; i++)
            stat.above[i] = filt_reg > {thr[i], 8'd0};
    end

endmodule

@@ rtl/oasc_steer.sv @@
// ----------------------------------------------------------------------------
// oasc_steer
// merge stage: drive state machine, pd steering law and steering smoother
// ----------------------------------------------------------------------------
module oasc_steer
    import oasc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_t      ctrl,
    input  lane_stat_t left,
    input  lane_stat_t center,
    input  lane_stat_t right,
    input  logic [7:0] kp_gain,
    input  logic [7:0] kd_gain,
    input  logic [6:0] cruise_throttle,
    output result_t    result
);

    drive_state_t             state_reg, state_next;
    logic signed [14:0]       prev_error_reg;
    logic signed [23:0]       kp_prod_reg, kp_prod_next;
    logic signed [24:0]       kd_prod_reg, kd_prod_next;
    logic signed [15:0]       alt_target_reg, alt_target_next;
    logic signed [15:0]       target_reg, target_next;
    logic signed [23:0]       keep_prod_reg, keep_prod_next;
    logic signed [24:0]       new_prod_reg, new_prod_next;
    logic signed [15:0]       smooth_reg, smooth_next;

    logic signed [14:0]       err;
    logic signed [15:0]       deriv;
    logic signed [8:0]        kp_s, kd_s;
    logic signed [25:0]       t12, t12_cl;
    logic signed [17:0]       t_adj;
    logic signed [13:0]       pd_q8;
    logic signed [25:0]       s_sum, s_adj;
    logic signed [15:0]       st_adj;

    logic l_open, r_open, l_blk, r_blk, l_rec, r_rec, l_crit, r_crit;
    logic c_clear, c_blk, c_app;

    assign l_open  = left.above[AB_OPEN];
    assign r_open  = right.above[AB_OPEN];
    assign l_blk   = left.above[AB_BLOCKED];
    assign r_blk   = right.above[AB_BLOCKED];
    assign l_rec   = left.above[AB_RECOVER];
    assign r_rec   = right.above[AB_RECOVER];
    assign l_crit  = left.above[AB_CRITICAL];
    assign r_crit  = right.above[AB_CRITICAL];
    assign c_clear = center.above[AB_CLEAR];
    assign c_blk   = center.above[AB_BLOCKED];
    assign c_app   = center.above[AB_APPROACH];

    // next drive state
    always_comb
    begin
        state_next = state_reg;
        if (state_reg == DRV_REVERSE)
        begin
            priority if (l_open)
                state_next = DRV_LEFT;
            else if (r_open)
                state_next = DRV_RIGHT;
            else if (c_clear && l_rec && r_rec)
                state_next = DRV_STRAIGHT;
        end
        else if (!c_blk || !l_blk || !r_blk)
            state_next = DRV_REVERSE;
        else if (state_reg == DRV_LEFT || state_reg == DRV_RIGHT)
        begin
            if (c_clear)
                state_next = DRV_STRAIGHT;
        end
        else if (!c_app)
        begin
            priority if (l_open)
                state_next = DRV_LEFT;
            else if (r_open)
                state_next = DRV_RIGHT;
            else
                state_next = DRV_REVERSE;
        end
        else
            state_next = DRV_STRAIGHT;
    end

    // fixed targets of turning and reverse
    always_comb
    begin
        unique case (state_next)
            DRV_LEFT:  alt_target_next = -TURN_TARGET;
            DRV_RIGHT: alt_target_next = TURN_TARGET;
            DRV_REVERSE:
            begin
                priority if (!c_blk && l_crit && r_crit)
                    alt_target_next = (left.filt > right.filt) ? REVERSE_TARGET
                                                               : -REVERSE_TARGET;
                else if (!l_crit)
                    alt_target_next = -REVERSE_TARGET;
                else if (!r_crit)
                    alt_target_next = REVERSE_TARGET;
                else
                    alt_target_next = '0;
            end
            default:   alt_target_next = '0;
        endcase
    end

    // pd products
    assign err          = $signed({1'b0, right.filt}) - $signed({1'b0, left.filt});
    assign deriv        = 16'(err) - 16'(prev_error_reg);
    assign kp_s         = $signed({1'b0, kp_gain});
    assign kd_s         = $signed({1'b0, kd_gain});
    assign kp_prod_next = err * kp_s;
    assign kd_prod_next = deriv * kd_s;

    // sum, clamp and q12 to q8 toward zero
    always_comb
    begin
        t12 = 26'(kp_prod_reg) + 26'(kd_prod_reg);
        if (t12 > STRAIGHT_CLAMP)
            t12_cl = STRAIGHT_CLAMP;
        else if (t12 < -STRAIGHT_CLAMP)
            t12_cl = -STRAIGHT_CLAMP;
        else
            t12_cl = t12;
        t_adj = 18'(t12_cl) + $signed({14'd0, {4{t12_cl[25]}}});
        pd_q8 = t_adj[17:4];
        target_next = (state_reg == DRV_STRAIGHT) ? 16'(pd_q8) : alt_target_reg;
    end

    // steering smoother
    assign keep_prod_next = smooth_reg * STEER_KEEP_W;
    assign new_prod_next  = target_reg * STEER_NEW_W;

    always_comb
    begin
        s_sum       = 26'(keep_prod_reg) + 26'(new_prod_reg);
        s_adj       = s_sum + $signed({18'd0, {8{s_sum[25]}}});
        smooth_next = s_adj[23:8];
        st_adj      = smooth_next + $signed({8'd0, {8{smooth_next[15]}}});
    end

    always_comb
    begin
        result.steering   = st_adj[14:8];
        result.drive_mode = state_reg;
        unique case (state_reg)
            DRV_STRAIGHT:        result.throttle = $signed({1'b0, cruise_throttle});
            DRV_LEFT, DRV_RIGHT: result.throttle = THR_TURN;
            default:             result.throttle = THR_REVERSE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= DRV_STRAIGHT;
            prev_error_reg <= '0;
            smooth_reg     <= '0;
        end
        else
        begin
            if (ctrl.decide)
            begin
                state_reg <= state_next;
                if (state_next == DRV_STRAIGHT)
                    prev_error_reg <= err;
            end
            if (ctrl.finish)
                smooth_reg <= smooth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.decide)
        begin
            kp_prod_reg    <= kp_prod_next;
            kd_prod_reg    <= kd_prod_next;
            alt_target_reg <= alt_target_next;
        end
        if (ctrl.pd)
            target_reg <= target_next;
        if (ctrl.smooth)
        begin
            keep_prod_reg <= keep_prod_next;
            new_prod_reg  <= new_prod_next;
        end
    end

endmodule

@@ rtl/obstacle_avoid_steering_controller.sv @@
// ----------------------------------------------------------------------------
// obstacle_avoid_steering_controller
// range filtering, drive state selection and smoothed steering per tick
// ----------------------------------------------------------------------------
// usage
// - s_axis: one beat per control tick; tdata holds left, center and right
//   range in cm, tuser holds the auto mode flag
// - m_axis: one beat per tick taken in auto mode with throttle and steering
//   in tdata and the drive mode in tuser; manual ticks only update filters
// - cfg: register writes, index in cfg_addr, always ready; write only while
//   the block is idle; indexes beyond the register list are dropped
// - three filter lanes work side by side on the three ranges; a merge stage
//   runs the drive state machine, the pd law and the steering smoother
// - the merge stage runs its decide, pd, smooth and finish steps in order,
//   one tick at a time; the input is taken again in the finish step, while
//   the previous result waits in the output register
// - a stalled receiver holds the finish step and with it the input side
// - reset clears filters, drive state, steering history and loads register
//   defaults
// ----------------------------------------------------------------------------
module obstacle_avoid_steering_controller
    import oasc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // dist_left, dist_center, dist_right, zero pad
    input  logic [0:0]  s_axis_tuser,   // auto_mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // throttle, steering, zero pad
    output logic [1:0]  m_axis_tuser,   // drive_mode

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_addr,
    input  logic [7:0]  cfg_data
);

    // configuration registers
    logic [5:0] open_side_reg;
    logic [5:0] center_clear_reg;
    logic [5:0] center_blocked_reg;
    logic [5:0] side_blocked_reg;
    logic [5:0] center_approach_reg;
    logic [7:0] kp_gain_reg;
    logic [7:0] kd_gain_reg;
    logic [6:0] cruise_reg;

    seq_state_t seq_reg, seq_next;
    ctrl_t      ctrl;
    logic       in_beat;
    logic       out_free;

    lane_stat_t left_stat, center_stat, right_stat;
    thr_vec_t   side_thr, center_thr;
    result_t    result;

    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic [1:0]  m_user_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_side_reg       <= 6'd35;
            center_clear_reg    <= 6'd20;
            center_blocked_reg  <= 6'd12;
            side_blocked_reg    <= 6'd7;
            center_approach_reg <= 6'd43;
            kp_gain_reg         <= 8'd56;
            kd_gain_reg         <= 8'd56;
            cruise_reg          <= 7'd52;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                REG_OPEN_SIDE:       open_side_reg       <= cfg_data[5:0];
                REG_CENTER_CLEAR:    center_clear_reg    <= cfg_data[5:0];
                REG_CENTER_BLOCKED:  center_blocked_reg  <= cfg_data[5:0];
                REG_SIDE_BLOCKED:    side_blocked_reg    <= cfg_data[5:0];
                REG_CENTER_APPROACH: center_approach_reg <= cfg_data[5:0];
                REG_KP_GAIN:         kp_gain_reg         <= cfg_data;
                REG_KD_GAIN:         kd_gain_reg         <= cfg_data;
                REG_CRUISE:          cruise_reg          <= cfg_data[6:0];
                default:             ;
            endcase
        end
    end

    // handshake: the output slot frees when it is empty or being drained
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (seq_reg == SEQ_IDLE) || (seq_reg == SEQ_FINISH && out_free);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SEQ_IDLE:
                if (in_beat && s_axis_tuser[0])
                    seq_next = SEQ_DECIDE;
            SEQ_DECIDE: seq_next = SEQ_PD;
            SEQ_PD:     seq_next = SEQ_SMOOTH;
            SEQ_SMOOTH: seq_next = SEQ_FINISH;
            SEQ_FINISH:
                if (out_free)
                    seq_next = (in_beat && s_axis_tuser[0]) ? SEQ_DECIDE : SEQ_IDLE;
            default:    seq_next = SEQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctrl        = '0;
        ctrl.decide = (seq_reg == SEQ_DECIDE);
        ctrl.pd     = (seq_reg == SEQ_PD);
        ctrl.smooth = (seq_reg == SEQ_SMOOTH);
        ctrl.finish = (seq_reg == SEQ_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seq_reg <= SEQ_IDLE;
        else
            seq_reg <= seq_next;
    end

    // compare thresholds of the lanes
    assign side_thr[AB_OPEN]     = open_side_reg;
    assign side_thr[AB_BLOCKED]  = side_blocked_reg;
    assign side_thr[AB_RECOVER]  = SIDE_RECOVER_CM;
    assign side_thr[AB_CRITICAL] = SIDE_CRITICAL_CM;

    assign center_thr[AB_CLEAR]    = center_clear_reg;
    assign center_thr[AB_BLOCKED]  = center_blocked_reg;
    assign center_thr[AB_APPROACH] = center_approach_reg;
    assign center_thr[3]           = center_clear_reg;

    oasc_lane u_lane_left (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_beat),
        .raw   (s_axis_tdata[10:0]),
        .limit (SIDE_LIMIT_CM),
        .thr   (side_thr),
        .stat  (left_stat)
    );

    oasc_lane u_lane_center (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_beat),
        .raw   (s_axis_tdata[21:11]),
        .limit (CENTER_LIMIT_CM),
        .thr   (center_thr),
        .stat  (center_stat)
    );

    oasc_lane u_lane_right (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_beat),
        .raw   (s_axis_tdata[32:22]),
        .limit (SIDE_LIMIT_CM),
        .thr   (side_thr),
        .stat  (right_stat)
    );

    oasc_steer u_steer (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .left            (left_stat),
        .center          (center_stat),
        .right           (right_stat),
        .kp_gain         (kp_gain_reg),
        .kd_gain         (kd_gain_reg),
        .cruise_throttle (cruise_reg),
        .result          (result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (ctrl.finish)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            m_data_reg <= {1'b0, result.steering, result.throttle};
            m_user_reg <= result.drive_mode;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // a manual tick never starts the merge stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && !s_axis_tuser[0]) |=> (seq_reg == SEQ_IDLE))
        else $error("manual tick started the merge stage");

    // a result beat is loaded only from the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(seq_reg == SEQ_FINISH))
        else $error("result beat loaded outside the finish step");

    // no input beat in the decide, pd and smooth steps of the merge stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_DECIDE || seq_reg == SEQ_PD || seq_reg == SEQ_SMOOTH)
        |-> !s_axis_tready)
        else $error("input taken while the merge stage is busy");

    // the center filter stays within its clipped range
    assert property (@(posedge clk) disable iff (!rst_n)
        center_stat.filt <= {CENTER_LIMIT_CM, 8'd0})
        else $error("center filter out of range");

endmodule
